// ===== src/dqfa_pkg.sv =====
// Shared types, constants and the answer byte table for the DNS fixed answer unit.
package dqfa_pkg;

    // Query bytes at or beyond this position are dropped.
    localparam int MAX_QUERY_BYTES = 127;
    localparam int POS_W = $clog2(MAX_QUERY_BYTES + 1);

    // Header layout and answer record constants.
    localparam logic [POS_W-1:0] POS_FLAGS   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_QD_HI   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_QD_LO   = POS_W'(5);
    localparam logic [POS_W-1:0] POS_AN_HI   = POS_W'(6);
    localparam logic [POS_W-1:0] POS_AN_LO   = POS_W'(7);
    localparam logic [POS_W-1:0] NAME_START  = POS_W'(12);
    localparam logic [7:0]  RESPONSE_FLAG    = 8'h80;
    localparam logic [15:0] NAME_POINTER     = 16'hC000 | 16'(NAME_START);
    localparam logic [31:0] ANSWER_TTL       = 32'd300;
    localparam logic [15:0] ANSWER_ADDR_LEN  = 16'd4;
    localparam logic [31:0] IPV4_RESET       = 32'hC0A8_0401;

    // One echo slot followed by the sixteen answer bytes.
    localparam int ANSWER_BYTES = 16;
    localparam int STEP_W = $clog2(ANSWER_BYTES + 1);
    localparam logic [STEP_W-1:0] STEP_ECHO = '0;
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(ANSWER_BYTES);

    // Type and class capture counts up to four bytes.
    localparam int TC_BYTES = 4;
    localparam int TC_CNT_W = 3;

    // Queue between the front and the back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    // Configuration register map.
    localparam int PADDR_W = 3;
    localparam logic REG_ANSWER_IPV4 = 1'b0;

    typedef struct packed {
        logic [7:0] query_byte;
        logic       query_last;
    } query_t;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic       reply_last;
    } reply_t;

    // Classified item handed from the front to the back end.
    typedef struct packed {
        logic [7:0]  echo_byte;
        logic        has_echo;
        logic        is_last;
        logic [31:0] type_class;
    } entry_t;

    // Byte idx of the appended answer record.
    function automatic logic [7:0] answer_byte(input logic [3:0] idx,
                                               input logic [31:0] type_class,
                                               input logic [31:0] ipv4);
        logic [7:0] b;
        case (idx)
            4'd0:    b = NAME_POINTER[15:8];
            4'd1:    b = NAME_POINTER[7:0];
            4'd2:    b = type_class[31:24];
            4'd3:    b = type_class[23:16];
            4'd4:    b = type_class[15:8];
            4'd5:    b = type_class[7:0];
            4'd6:    b = ANSWER_TTL[31:24];
            4'd7:    b = ANSWER_TTL[23:16];
            4'd8:    b = ANSWER_TTL[15:8];
            4'd9:    b = ANSWER_TTL[7:0];
            4'd10:   b = ANSWER_ADDR_LEN[15:8];
            4'd11:   b = ANSWER_ADDR_LEN[7:0];
            4'd12:   b = ipv4[31:24];
            4'd13:   b = ipv4[23:16];
            4'd14:   b = ipv4[15:8];
            default: b = ipv4[7:0];
        endcase
        return b;
    endfunction

endpackage

// ===== src/dqfa_front.sv =====
// Front end: takes query bytes, rewrites the header and scans the question.
module dqfa_front
    import dqfa_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_valid,
    output logic   s_ready,
    input  query_t s_payload,
    input  logic   q_full,
    output logic   q_push,
    output entry_t q_entry
);

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_NAME,
        PH_CAPTURE,
        PH_DONE
    } phase_t;

    phase_t              phase_reg, phase_next;
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic [15:0]         qd_reg, qd_next;
    logic [31:0]         tc_reg, tc_next, tc_upd;
    logic [TC_CNT_W-1:0] tc_cnt_reg, tc_cnt_next;
    logic                accept;
    logic                keep;
    logic [7:0]          b;
    logic [7:0]          echo;
    phase_t              ph;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_payload.query_byte;
    assign keep    = pos_reg < POS_W'(MAX_QUERY_BYTES);

    // Header rewrite and question scan for one accepted byte.
    always_comb begin
        phase_next  = phase_reg;
        pos_next    = pos_reg;
        qd_next     = qd_reg;
        tc_upd      = tc_reg;
        tc_cnt_next = tc_cnt_reg;
        echo        = b;
        ph          = phase_reg;
        if (keep) begin
            case (pos_reg)
                POS_FLAGS: echo = b | RESPONSE_FLAG;
                POS_QD_HI: qd_next[15:8] = b;
                POS_QD_LO: qd_next[7:0] = b;
                POS_AN_HI: echo = qd_reg[15:8];
                POS_AN_LO: echo = qd_reg[7:0];
                default:   echo = b;
            endcase
            if (pos_reg >= NAME_START) begin
                if (ph == PH_HEADER) begin
                    ph = PH_NAME;
                end
                phase_next = ph;
                if (ph == PH_NAME) begin
                    if (b == 8'd0) begin
                        phase_next = PH_CAPTURE;
                    end
                end else if (ph == PH_CAPTURE) begin
                    case (tc_cnt_reg[1:0])
                        2'd0:    tc_upd[31:24] = tc_reg[31:24] | b;
                        2'd1:    tc_upd[23:16] = tc_reg[23:16] | b;
                        2'd2:    tc_upd[15:8]  = tc_reg[15:8] | b;
                        default: tc_upd[7:0]   = tc_reg[7:0] | b;
                    endcase
                    tc_cnt_next = tc_cnt_reg + TC_CNT_W'(1);
                    if (tc_cnt_next >= TC_CNT_W'(TC_BYTES)) begin
                        phase_next = PH_DONE;
                    end
                end
            end
            pos_next = pos_reg + POS_W'(1);
        end
        tc_next = tc_upd;
        // The answer closes the packet, so all scan state starts afresh.
        if (s_payload.query_last) begin
            phase_next  = PH_HEADER;
            pos_next    = '0;
            qd_next     = '0;
            tc_next     = '0;
            tc_cnt_next = '0;
        end
    end

    // Hand the classified item to the queue.
    assign q_push              = accept && (keep || s_payload.query_last);
    assign q_entry.echo_byte   = echo;
    assign q_entry.has_echo    = keep;
    assign q_entry.is_last     = s_payload.query_last;
    assign q_entry.type_class  = tc_upd;

    // Scan state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= '0;
            qd_reg     <= '0;
            tc_reg     <= '0;
            tc_cnt_reg <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            qd_reg     <= qd_next;
            tc_reg     <= tc_next;
            tc_cnt_reg <= tc_cnt_next;
        end
    end

endmodule

// ===== src/dqfa_queue.sv =====
// Short register queue between the front and the back end.
module dqfa_queue
    import dqfa_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output entry_t head,
    output logic   empty,
    output logic   full
);

    entry_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;
    logic                do_push;
    logic                do_pop;

    assign empty   = cnt_reg == '0;
    assign full    = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = slot_reg[rd_ptr_reg];

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (do_push && !do_pop) begin
                cnt_reg <= cnt_reg + QCNT_W'(1);
            end else if (do_pop && !do_push) begin
                cnt_reg <= cnt_reg - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== src/dqfa_back.sv =====
// Back end: streams the echoed byte of each queued item and, after a last item, the answer record.
module dqfa_back
    import dqfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  entry_t      head,
    input  logic        q_empty,
    output logic        q_pop,
    input  logic [31:0] answer_ipv4,
    output logic        m_valid,
    input  logic        m_ready,
    output reply_t      m_payload
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic [STEP_W-1:0] k;
    logic              m_valid_reg;
    reply_t            m_payload_reg;
    reply_t            out_next;
    logic              load;
    logic              [STEP_W-1:0] k_dec;

    assign load = !q_empty && (!m_valid_reg || m_ready);

    // An item without an echo starts directly on the answer.
    assign k     = (step_reg == STEP_ECHO && !head.has_echo) ? STEP_W'(1) : step_reg;
    assign k_dec = k - STEP_W'(1);

    // Pick the byte for the current step and decide when the item is done.
    always_comb begin
        if (k == STEP_ECHO) begin
            out_next.reply_byte = head.echo_byte;
        end else begin
            out_next.reply_byte = answer_byte(k_dec[3:0], head.type_class, answer_ipv4);
        end
        out_next.reply_last = k == STEP_LAST;
        q_pop     = load && (k == STEP_LAST || (k == STEP_ECHO && !head.is_last));
        step_next = q_pop ? STEP_ECHO : k + STEP_W'(1);
    end

    // Output register; it refills in the cycle its transfer completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            step_reg    <= STEP_ECHO;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                step_reg    <= step_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_payload_reg <= out_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

endmodule

// ===== src/dns_query_to_fixed_answer_unit.sv =====
// Top level: DNS query to fixed answer responder with its configuration port.
// An echoed byte passes through the queue and then the output register before it is presented.
// Throughput: one reply byte per cycle while m_ready is high; a last query byte adds sixteen
// answer bytes, and intake stalls once the four-entry queue to the back end is full.
// Reset (aresetn low, synchronous) clears the scan state, the queue and the output,
// and sets answer_ipv4 to 192.168.4.1.
module dns_query_to_fixed_answer_unit
    import dqfa_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  query_t             s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output reply_t             m_payload,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic        q_full;
    logic        q_empty;
    logic        q_push;
    logic        q_pop;
    entry_t      q_entry;
    entry_t      q_head;
    logic [31:0] ipv4_reg;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_ANSWER_IPV4) ? ipv4_reg : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ipv4_reg <= IPV4_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_ANSWER_IPV4) begin
            ipv4_reg <= pwdata;
        end
    end

    dqfa_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    dqfa_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .empty      (q_empty),
        .full       (q_full)
    );

    dqfa_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head        (q_head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .answer_ipv4 (ipv4_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_payload   (m_payload)
    );

endmodule
